[rtl/wsfp_pkg.sv]
// Shared types and constants for the WebSocket frame parser.
package wsfp_pkg;

   // Opcodes that get special handling; every other opcode is data.
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Result classes.
   localparam logic [1:0] CLASS_DATA  = 2'd0;
   localparam logic [1:0] CLASS_PING  = 2'd1;
   localparam logic [1:0] CLASS_CLOSE = 2'd2;

   // Default depth of the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;

   // One queued result, still masked; the output stage unmasks and classifies it.
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic       has_byte;
      logic [3:0] opcode;
      logic       last;
   } wsfp_desc_type;

endpackage

[rtl/wsfp_front.sv]
// Header and length parser: takes one received byte a beat and queues results.
module wsfp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_rx_byte,
   input  logic                   q_full,
   output logic                   req_ready,
   output logic                   q_push,
   output wsfp_pkg::wsfp_desc_type q_desc
);

   localparam logic [2:0] PH_B0    = 3'd0;
   localparam logic [2:0] PH_B1    = 3'd1;
   localparam logic [2:0] PH_LEN16 = 3'd2;
   localparam logic [2:0] PH_LEN64 = 3'd3;
   localparam logic [2:0] PH_KEY   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic        closed_ff, closed_in;

   logic        accept;
   logic [7:0]  b;
   logic [63:0] len_next;
   logic [63:0] hdr_len;
   logic        hdr_done;
   logic        data_last;
   logic [7:0]  key_byte;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_rx_byte;

   // Pick the key byte for the current payload position, first key byte on top.
   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign len_next  = {remain_ff[55:0], b};
   assign data_last = (remain_ff == 64'd1);

   // Parser state step for one accepted beat.
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      key_in     = key_ff;
      remain_in  = remain_ff;
      key_idx_in = key_idx_ff;
      closed_in  = closed_ff;
      hdr_done   = 1'b0;
      hdr_len    = remain_ff;
      q_push     = 1'b0;
      q_desc     = '0;
      q_desc.opcode = opcode_ff;

      if (accept && !closed_ff) begin
         unique case (phase_ff)
            PH_B0: begin
               opcode_in = b[3:0];
               phase_in  = PH_B1;
            end
            PH_B1: begin
               mask_in    = b[7];
               key_in     = '0;
               hdr_cnt_in = '0;
               if (b[6:0] == LEN7_EXT16) begin
                  remain_in = '0;
                  phase_in  = PH_LEN16;
               end else if (b[6:0] == LEN7_EXT64) begin
                  remain_in = '0;
                  phase_in  = PH_LEN64;
               end else begin
                  remain_in = {57'd0, b[6:0]};
                  hdr_len   = {57'd0, b[6:0]};
                  if (b[7]) begin
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_LEN16, PH_LEN64: begin
               remain_in = len_next;
               hdr_len   = len_next;
               if ((phase_ff == PH_LEN16 && hdr_cnt_ff >= 3'd1) || hdr_cnt_ff >= 3'd7) begin
                  hdr_cnt_in = '0;
                  if (mask_ff) begin
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], b};
               if (hdr_cnt_ff >= 3'd3) begin
                  hdr_done = 1'b1;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end
            end
            PH_DATA: begin
               key_idx_in = key_idx_ff + 2'd1;
               remain_in  = remain_ff - 64'd1;
               if (data_last) begin
                  phase_in = PH_B0;
               end
               if (opcode_ff == wsfp_pkg::OP_CLOSE) begin
                  if (data_last) begin
                     closed_in   = 1'b1;
                     q_push      = 1'b1;
                     q_desc.last = 1'b1;
                  end
               end else if (opcode_ff != wsfp_pkg::OP_PONG) begin
                  q_push          = 1'b1;
                  q_desc.raw_byte = b;
                  q_desc.key_byte = key_byte;
                  q_desc.has_byte = 1'b1;
                  q_desc.last     = data_last;
               end
            end
            default: begin
               phase_in   = PH_B0;
               hdr_cnt_in = '0;
            end
         endcase

         // Header finished: enter the payload or, unless the frame is a pong, give the empty-frame marker.
         if (hdr_done) begin
            key_idx_in = '0;
            hdr_cnt_in = '0;
            if (hdr_len != 64'd0) begin
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_B0;
               if (opcode_ff != wsfp_pkg::OP_PONG) begin
                  q_push      = 1'b1;
                  q_desc.last = 1'b1;
                  if (opcode_ff == wsfp_pkg::OP_CLOSE) begin
                     closed_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_B0;
         hdr_cnt_ff <= '0;
         opcode_ff  <= '0;
         mask_ff    <= 1'b0;
         key_ff     <= '0;
         remain_ff  <= '0;
         key_idx_ff <= '0;
         closed_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         key_ff     <= key_in;
         remain_ff  <= remain_in;
         key_idx_ff <= key_idx_in;
         closed_ff  <= closed_in;
      end
   end

   // Once the close marker is queued, nothing else may follow it.
   a_no_push_after_close: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !q_push)
      else $error("result queued after close");

endmodule

[rtl/wsfp_fifo.sv]
// Small result queue between the parser and the output stage.
module wsfp_fifo #(
   parameter int DEPTH = wsfp_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wsfp_pkg::wsfp_desc_type push_desc,
   input  logic                    pop,
   output wsfp_pkg::wsfp_desc_type head_desc,
   output logic                    full,
   output logic                    empty
);

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   wsfp_pkg::wsfp_desc_type entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CountW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

[rtl/wsfp_back.sv]
// Output stage: unmasks and classifies queued results into the result register.
module wsfp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  wsfp_pkg::wsfp_desc_type head_desc,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_payload_byte,
   output logic                    rsp_has_byte,
   output logic [1:0]              rsp_frame_class,
   output logic [3:0]              rsp_frame_opcode,
   output logic                    rsp_frame_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff;
   logic [1:0] class_ff, class_in;
   logic [3:0] opcode_ff;
   logic       last_ff;

   // Load a new beat when the register is empty or being drained.
   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Unmask real bytes; markers carry zero.
   assign byte_in = head_desc.has_byte ? (head_desc.raw_byte ^ head_desc.key_byte) : 8'd0;

   // Class decode from the opcode.
   always_comb begin
      unique case (head_desc.opcode)
         wsfp_pkg::OP_CLOSE: class_in = wsfp_pkg::CLASS_CLOSE;
         wsfp_pkg::OP_PING:  class_in = wsfp_pkg::CLASS_PING;
         default:            class_in = wsfp_pkg::CLASS_DATA;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         byte_ff   <= byte_in;
         has_ff    <= head_desc.has_byte;
         class_ff  <= class_in;
         opcode_ff <= head_desc.opcode;
         last_ff   <= head_desc.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_has_byte     = has_ff;
   assign rsp_frame_class  = class_ff;
   assign rsp_frame_opcode = opcode_ff;
   assign rsp_frame_last   = last_ff;

   // A marker without a byte must be a frame end with a zero byte.
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !has_ff) |-> (byte_ff == 8'd0 && last_ff))
      else $error("malformed marker result");

endmodule

[rtl/websocket_frame_parser.sv]
// Top level of the WebSocket receive-side frame parser.
//
// The req channel takes one received byte per beat (req_rx_byte). The rsp
// channel gives at most one result per input byte: an unmasked payload byte
// with its frame class, opcode and last flag, an empty-frame marker, or the
// close marker. Pong frames give no result, and header bytes give none
// except the last header byte of an empty frame, which gives its marker.
// Throughput is one byte per cycle while the queue is not full; the header
// parser does its whole step, including the 64-bit length count, in the
// cycle the byte is accepted. A result is written into the queue and then
// loaded into the output register that drives rsp, once that is free.
// A small queue (QUEUE_DEPTH entries) sits between the parser and the output
// register. When the receiver stalls, the queue fills and req_ready drops
// once it is full; no beat is lost. After the close marker the block takes
// and drops every byte until reset. Reset returns the parser to waiting for
// the first header byte, empties the queue and clears rsp_valid.
module websocket_frame_parser #(
   parameter int QUEUE_DEPTH = wsfp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_frame_class,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_last
);

   logic                    q_full;
   logic                    q_empty;
   logic                    q_push;
   logic                    q_pop;
   wsfp_pkg::wsfp_desc_type q_desc;
   wsfp_pkg::wsfp_desc_type head_desc;

   wsfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .req_ready   (req_ready),
      .q_push      (q_push),
      .q_desc      (q_desc)
   );

   wsfp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   wsfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_desc        (head_desc),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_frame_class  (rsp_frame_class),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench for the WebSocket frame parser: byte stream in, deframed results out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;

   // Parser phases of the expected-result model.
   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_LEN16, PH_LEN64, PH_KEY, PH_PAYLOAD
   } parse_phase_type;

   // How the payload length is encoded in the header.
   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_enc_type;

   typedef struct {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic [1:0] frame_class;
      logic [3:0] frame_opcode;
      logic       frame_last;
   } deframed_type;

   // Tracks the frame state of the byte stream and holds the results still owed.
   class deframer_scoreboard_type;
      deframed_type    deframed_q[$];
      int              errors;
      parse_phase_type phase;
      logic [2:0]      hdr_count;
      logic [3:0]      opcode;
      logic            masked;
      logic [31:0]     key_word;
      logic [63:0]     remaining;
      logic [1:0]      key_idx;
      logic            closed;

      function new();
         errors    = 0;
         phase     = PH_HDR0;
         hdr_count = '0;
         opcode    = '0;
         masked    = 1'b0;
         key_word  = '0;
         remaining = '0;
         key_idx   = '0;
         closed    = 1'b0;
      endfunction

      // Prints one line for each mismatch and counts it.
      function void report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endfunction

      function void push_result(logic [7:0] data, logic has, logic last);
         deframed_type r;
         r.payload_byte = data;
         r.has_byte     = has;
         r.frame_class  = (opcode == wsfp_pkg::OP_CLOSE) ? wsfp_pkg::CLASS_CLOSE :
                          (opcode == wsfp_pkg::OP_PING)  ? wsfp_pkg::CLASS_PING :
                                                           wsfp_pkg::CLASS_DATA;
         r.frame_opcode = opcode;
         r.frame_last   = last;
         deframed_q.insert(deframed_q.size(), r);
      endfunction

      // The header is complete: an empty frame other than a pong gives its marker at once.
      function void finish_header();
         key_idx   = '0;
         hdr_count = '0;
         if (remaining != 0) begin
            phase = PH_PAYLOAD;
         end else begin
            phase = PH_HDR0;
            if (opcode != wsfp_pkg::OP_PONG) begin
               if (opcode == wsfp_pkg::OP_CLOSE) closed = 1'b1;
               push_result(8'h00, 1'b0, 1'b1);
            end
         end
      endfunction

      function void finish_length();
         hdr_count = '0;
         if (masked) phase = PH_KEY;
         else finish_header();
      endfunction

      // Advances the frame state by one accepted byte.
      function void deframe_byte(logic [7:0] b);
         logic [7:0] data;
         logic       last;
         if (closed) return;
         case (phase)
            PH_HDR0: begin
               opcode = b[3:0];
               phase  = PH_HDR1;
            end
            PH_HDR1: begin
               masked    = b[7];
               key_word  = '0;
               hdr_count = '0;
               remaining = '0;
               if (b[6:0] == 7'd126) phase = PH_LEN16;
               else if (b[6:0] == 7'd127) phase = PH_LEN64;
               else begin
                  remaining = {57'd0, b[6:0]};
                  finish_length();
               end
            end
            PH_LEN16: begin
               remaining = {remaining[55:0], b};
               if (hdr_count >= 1) finish_length();
               else hdr_count++;
            end
            PH_LEN64: begin
               remaining = {remaining[55:0], b};
               if (hdr_count >= 7) finish_length();
               else hdr_count++;
            end
            PH_KEY: begin
               key_word = {key_word[23:0], b};
               if (hdr_count >= 3) finish_header();
               else hdr_count++;
            end
            PH_PAYLOAD: begin
               // Key byte 0 sits in the top bits of the key.
               data = b ^ key_word[8 * (3 - key_idx) +: 8];
               key_idx++;
               remaining--;
               last = (remaining == 0);
               if (last) phase = PH_HDR0;
               if (opcode == wsfp_pkg::OP_CLOSE) begin
                  if (last) begin
                     closed = 1'b1;
                     push_result(8'h00, 1'b0, 1'b1);
                  end
               end else if (opcode != wsfp_pkg::OP_PONG) begin
                  push_result(data, 1'b1, last);
               end
            end
            default: begin
               phase     = PH_HDR0;
               hdr_count = '0;
            end
         endcase
      endfunction

      // Compares one accepted result with the oldest one owed.
      function void check_deframed(deframed_type got);
         deframed_type want;
         if (deframed_q.size() == 0) begin
            report($sformatf("result with none owed: byte %02h has %b opcode %h",
                             got.payload_byte, got.has_byte, got.frame_opcode));
            return;
         end
         want = deframed_q.pop_front();
         if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %02h, wanted %02h",
                             got.payload_byte, want.payload_byte));
         if (got.has_byte !== want.has_byte)
            report($sformatf("has_byte %b, wanted %b", got.has_byte, want.has_byte));
         if (got.frame_class !== want.frame_class)
            report($sformatf("frame_class %0d, wanted %0d",
                             got.frame_class, want.frame_class));
         if (got.frame_opcode !== want.frame_opcode)
            report($sformatf("frame_opcode %h, wanted %h",
                             got.frame_opcode, want.frame_opcode));
         if (got.frame_last !== want.frame_last)
            report($sformatf("frame_last %b, wanted %b", got.frame_last, want.frame_last));
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic [1:0] rsp_frame_class;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_frame_last;

   int send_idle_pct = 35;
   int recv_idle_pct = 47;
   int bytes_sent    = 0;
   int idle_cycles   = 0;

   deframer_scoreboard_type sb = new();

   websocket_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_frame_class  (rsp_frame_class),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_frame_last   (rsp_frame_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one byte, with random gaps in front, and holds it until the beat is taken.
   task automatic send_beat(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.deframe_byte(b);
      bytes_sent++;
   endtask

   // Sends one frame: header, extended length, optional key, then random payload.
   task automatic drive_frame(input logic [3:0] opcode, input logic masked,
                              input logic [31:0] key, input logic [63:0] len,
                              input len_enc_type enc, input int body);
      logic [3:0] flags;
      logic [6:0] len7;
      flags = 4'($urandom_range(15));
      len7  = (enc == LEN_SHORT) ? len[6:0] : (enc == LEN_16) ? 7'd126 : 7'd127;
      send_beat({flags, opcode});
      send_beat({masked, len7});
      if (enc == LEN_16) begin
         send_beat(len[15:8]);
         send_beat(len[7:0]);
      end else if (enc == LEN_64) begin
         for (int i = 7; i >= 0; i--) send_beat(len[8 * i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_beat(key[8 * i +: 8]);
      end
      for (int i = 0; i < body; i++) send_beat(8'($urandom_range(255)));
   endtask

   // A random data, ping or pong frame, mostly short.
   task automatic send_random_frame();
      logic [3:0]  opcode;
      int          pick;
      int          len;
      len_enc_type enc;
      pick = $urandom_range(99);
      if (pick < 55) begin
         do opcode = 4'($urandom_range(15));
         while (opcode == wsfp_pkg::OP_CLOSE || opcode == wsfp_pkg::OP_PING ||
                opcode == wsfp_pkg::OP_PONG);
      end else if (pick < 80) begin
         opcode = wsfp_pkg::OP_PING;
      end else begin
         opcode = wsfp_pkg::OP_PONG;
      end
      pick = $urandom_range(99);
      if (pick < 10) len = 0;
      else if (pick < 95) len = $urandom_range(12, 1);
      else len = $urandom_range(130, 13);
      pick = $urandom_range(99);
      if (len > 125) enc = (pick < 50) ? LEN_16 : LEN_64;
      else enc = (pick < 70) ? LEN_SHORT : (pick < 85) ? LEN_16 : LEN_64;
      drive_frame(opcode, 1'($urandom_range(1)), $urandom, 64'(len), enc, len);
   endtask

   // Holds the input quiet until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.deframed_q.size() != 0);
   endtask

   task automatic send_random_bytes(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_frame();
   endtask

   // Result side: random back-pressure, and a check on every beat taken.
   initial begin
      deframed_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.payload_byte = rsp_payload_byte;
            got.has_byte     = rsp_has_byte;
            got.frame_class  = rsp_frame_class;
            got.frame_opcode = rsp_frame_opcode;
            got.frame_last   = rsp_frame_last;
            sb.check_deframed(got);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty data frame, empty masked ping, pong with payload, masked frame with an
      // all-ones key and the highest opcode, and a 16-bit length on a continuation.
      drive_frame(4'h1, 1'b0, 32'h0, 64'd0, LEN_SHORT, 0);
      drive_frame(wsfp_pkg::OP_PING, 1'b1, $urandom, 64'd0, LEN_SHORT, 0);
      drive_frame(wsfp_pkg::OP_PONG, 1'b0, 32'h0, 64'd2, LEN_SHORT, 2);
      drive_frame(4'hF, 1'b1, 32'hFFFF_FFFF, 64'd2, LEN_SHORT, 2);
      drive_frame(4'h0, 1'b0, 32'h0, 64'd1, LEN_16, 1);
      drain_results();

      // Random frames with the sender idling less than the receiver.
      send_random_bytes(70);
      drain_results();

      // The other way round.
      send_idle_pct = 47;
      recv_idle_pct = 35;
      send_random_bytes(70);
      drain_results();

      // No idling at all, including a longer frame with a 16-bit length field.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drive_frame(4'h2, 1'b1, $urandom, 64'd126, LEN_16, 126);
      send_random_bytes(70);
      drain_results();

      // The stream can only end once: an empty close, a close with payload,
      // or a frame whose 64-bit length has the top bit set.
      pick = $urandom_range(2);
      if (pick == 0) begin
         drive_frame(wsfp_pkg::OP_CLOSE, 1'($urandom_range(1)), $urandom, 64'd0,
                     LEN_SHORT, 0);
      end else if (pick == 1) begin
         len = $urandom_range(5, 1);
         drive_frame(wsfp_pkg::OP_CLOSE, 1'b1, $urandom, 64'(len), LEN_64, len);
      end else begin
         drive_frame(4'h1, 1'($urandom_range(1)), $urandom,
                     {1'b1, 31'($urandom), 32'($urandom)}, LEN_64, 30);
      end
      // Bytes after a close must be taken and dropped.
      for (int i = 0; i < 12; i++) send_beat(8'($urandom_range(255)));
      drain_results();
      repeat (20) @(posedge clock);

      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/wsfp_pkg.sv
rtl/wsfp_front.sv
rtl/wsfp_fifo.sv
rtl/wsfp_back.sv
rtl/websocket_frame_parser.sv
tb/tb.sv
